// ----- rtl/lph_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash table: result codes,
// fixed port widths, parameter defaults and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package lph_pkg;

  // parameter defaults
  localparam int unsigned TABLE_DEPTH_DEF   = 256;
  localparam int unsigned MAX_KEY_BYTES_DEF = 8;
  localparam int unsigned VALUE_BITS_DEF    = 32;

  // fixed port widths
  localparam int unsigned KEY_PORT_BITS   = 64;
  localparam int unsigned LEN_BITS        = 4;
  localparam int unsigned VALUE_PORT_BITS = 32;
  localparam int unsigned STATUS_BITS     = 3;
  localparam int unsigned SLOT_PORT_BITS  = 8;

  // hash multiplier 33 = (1 << 5) + 1
  localparam int unsigned HASH_SHIFT = 5;

  // result codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load;        // capture a new item
    logic    hash_step;   // fold one key byte into the hash
    logic    probe_init;  // start slot from the hash
    logic    rd;          // read the entry at the probe slot
    logic    advance;     // move to the next slot
    logic    wr_entry;    // store the item at the probe slot
    logic    clr_wr;      // clear one entry of the sweep after reset
    logic    res_en;      // register a result
    status_e res_status;
  } lph_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic hash_done;
    logic occ;
    logic match;
    logic insert;
    logic full;
    logic clr_last;
  } lph_sts_t;

endpackage
`default_nettype wire

// ----- rtl/lph_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer of the hash table: clearing sweep after reset, key hashing,
// probe read/check loop and result selection.
// ----------------------------------------------------------------------------
module lph_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire lph_pkg::lph_sts_t sts_i,
  output lph_pkg::lph_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.res_status   = lph_pkg::ST_NOT_FOUND;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.probe_init = 1'b1;
          state_d          = S_READ;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.occ) begin
          // empty slot ends the probe
          cmd_o.res_en = 1'b1;
          state_d      = S_IDLE;
          if (!sts_i.insert) begin
            cmd_o.res_status = lph_pkg::ST_NOT_FOUND;
          end else if (sts_i.full) begin
            cmd_o.res_status = lph_pkg::ST_FULL;
          end else begin
            cmd_o.res_status = lph_pkg::ST_INSERTED;
            cmd_o.wr_entry   = 1'b1;
          end
        end else if (sts_i.match) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = sts_i.insert ? lph_pkg::ST_DUPLICATE : lph_pkg::ST_FOUND;
          state_d          = S_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/lph_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lph_datapath
// Item registers, byte-serial hash, probe slot counter, entry memory,
// entry count and result registers.
// ----------------------------------------------------------------------------
module lph_datapath #(
  parameter int unsigned TABLE_DEPTH   = lph_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_KEY_BYTES = lph_pkg::MAX_KEY_BYTES_DEF,
  parameter int unsigned VALUE_BITS    = lph_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire lph_pkg::lph_cmd_t                     cmd_i,
  output lph_pkg::lph_sts_t                          sts_o,
  input  wire logic                                  mode_i,
  input  wire logic [lph_pkg::KEY_PORT_BITS-1:0]     key_bytes_i,
  input  wire logic [lph_pkg::LEN_BITS-1:0]          key_length_i,
  input  wire logic [lph_pkg::VALUE_PORT_BITS-1:0]   value_in_i,
  output logic                                       done_o,
  output logic [lph_pkg::STATUS_BITS-1:0]            status_o,
  output logic [lph_pkg::VALUE_PORT_BITS-1:0]        value_out_o,
  output logic [lph_pkg::SLOT_PORT_BITS-1:0]         slot_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_W  = 8 * MAX_KEY_BYTES;
  localparam int unsigned VAL_W  = (VALUE_BITS < lph_pkg::VALUE_PORT_BITS) ?
                                   VALUE_BITS : lph_pkg::VALUE_PORT_BITS;
  localparam int unsigned LEN_W  = lph_pkg::LEN_BITS;
  localparam int unsigned HEXT_W = SLOT_W + 8;
  localparam int unsigned ENT_W  = 1 + LEN_W + KEY_W + VAL_W;
  // entry layout: {occupied, length, key, value}
  localparam int unsigned VAL_LO = 0;
  localparam int unsigned KEY_LO = VAL_W;
  localparam int unsigned LEN_LO = VAL_W + KEY_W;
  localparam int unsigned OCC_B  = VAL_W + KEY_W + LEN_W;

  // item registers
  logic                 insert_q;
  logic [KEY_W-1:0]     key_q;
  logic [LEN_W-1:0]     len_q;
  logic [VAL_W-1:0]     value_q;
  logic [KEY_W-1:0]     hkey_q, hkey_d;
  logic [LEN_W-1:0]     hcnt_q, hcnt_d;
  logic [SLOT_W-1:0]    hash_q, hash_d;
  logic [SLOT_W-1:0]    slot_q;
  logic [SLOT_W-1:0]    clr_q;
  logic [SLOT_W-1:0]    count_q;
  logic [ENT_W-1:0]     store_q [TABLE_DEPTH];
  logic [ENT_W-1:0]     rd_q;

  // length saturation and key masking
  logic [LEN_W-1:0]     len_sat;
  logic [KEY_W-1:0]     key_mask;
  logic [KEY_W-1:0]     key_in;
  always_comb begin
    len_sat = (key_length_i > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_length_i;
    for (int b = 0; b < MAX_KEY_BYTES; b++) begin
      key_mask[b*8 +: 8] = (LEN_W'(b) < len_sat) ? 8'hFF : 8'h00;
    end
    key_in = key_bytes_i[KEY_W-1:0] & key_mask;
  end

  // one hash step h = h * 33 + byte, kept to the slot bits
  logic [HEXT_W-1:0] hash_ext;
  always_comb begin
    hash_ext = (HEXT_W'(hash_q) << lph_pkg::HASH_SHIFT) + HEXT_W'(hash_q)
               + HEXT_W'(hkey_q[7:0]);
    hash_d   = hash_q;
    hkey_d   = hkey_q;
    hcnt_d   = hcnt_q;
    if (cmd_i.load) begin
      hash_d = '0;
      hkey_d = key_in;
      hcnt_d = len_sat;
    end else if (cmd_i.hash_step) begin
      hash_d = hash_ext[SLOT_W-1:0];
      hkey_d = hkey_q >> 8;
      hcnt_d = hcnt_q - LEN_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    hkey_q <= hkey_d;
    if (cmd_i.load) begin
      insert_q <= mode_i;
      key_q    <= key_in;
      len_q    <= len_sat;
      value_q  <= value_in_i[VAL_W-1:0];
    end
    if (cmd_i.probe_init) begin
      slot_q <= hash_q;
    end else if (cmd_i.advance) begin
      slot_q <= slot_q + SLOT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q  <= '0;
      clr_q   <= '0;
      count_q <= '0;
    end else begin
      hcnt_q <= hcnt_d;
      if (cmd_i.clr_wr) clr_q <= clr_q + SLOT_W'(1);
      if (cmd_i.wr_entry) count_q <= count_q + SLOT_W'(1);
    end
  end

  // entry memory, one write and one registered read per cycle
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  logic [ENT_W-1:0]  mem_wd;
  always_comb begin
    mem_we = cmd_i.wr_entry | cmd_i.clr_wr;
    mem_wa = cmd_i.clr_wr ? clr_q : slot_q;
    mem_wd = cmd_i.clr_wr ? '0 : {1'b1, len_q, key_q, value_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_wa] <= mem_wd;
    if (cmd_i.rd) rd_q <= store_q[slot_q];
  end

  // status to the controller
  always_comb begin
    sts_o.hash_done = (hcnt_q == '0);
    sts_o.occ       = rd_q[OCC_B];
    sts_o.match     = (rd_q[LEN_LO +: LEN_W] == len_q) && (rd_q[KEY_LO +: KEY_W] == key_q);
    sts_o.insert    = insert_q;
    sts_o.full      = (count_q == SLOT_W'(TABLE_DEPTH - 1));
    sts_o.clr_last  = (clr_q == SLOT_W'(TABLE_DEPTH - 1));
  end

  // result registers
  logic [HEXT_W-1:0] slot_ext;
  assign slot_ext = HEXT_W'(slot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      status_o    <= cmd_i.res_status;
      value_out_o <= (cmd_i.res_status == lph_pkg::ST_FOUND) ?
                     lph_pkg::VALUE_PORT_BITS'(rd_q[VAL_LO +: VAL_W]) : '0;
      slot_o      <= (cmd_i.res_status == lph_pkg::ST_FULL) ?
                     '0 : slot_ext[lph_pkg::SLOT_PORT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.res_en;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sequence: after the start cycle an item of L key bytes is hashed one byte a
//   cycle, then each of its P probed slots, P >= 1, gets one memory read and
//   one compare; done_o is registered from the result of the last compare.
// Handshake: a new item is taken only while idle; busy falls as done_o rises.
// Reset: busy stays high while the entry memory is swept clear; results
//   cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key/value table with open addressing and linear probing: lookup and insert
// of keys up to eight bytes, start slot from the hash h = h*33 + byte.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH   = lph_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_KEY_BYTES = lph_pkg::MAX_KEY_BYTES_DEF,
  parameter int unsigned VALUE_BITS    = lph_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                mode_i,
  input  wire logic [lph_pkg::KEY_PORT_BITS-1:0]   key_bytes_i,
  input  wire logic [lph_pkg::LEN_BITS-1:0]        key_length_i,
  input  wire logic [lph_pkg::VALUE_PORT_BITS-1:0] value_in_i,
  output logic                                     done_o,
  output logic [lph_pkg::STATUS_BITS-1:0]          status_o,
  output logic [lph_pkg::VALUE_PORT_BITS-1:0]      value_out_o,
  output logic [lph_pkg::SLOT_PORT_BITS-1:0]       slot_o
);

  lph_pkg::lph_cmd_t cmd;
  lph_pkg::lph_sts_t sts;

  // sequencer
  lph_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // hash, probe and storage
  lph_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .VALUE_BITS    (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_i),
    .key_bytes_i  (key_bytes_i),
    .key_length_i (key_length_i),
    .value_in_i   (value_in_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .value_out_o  (value_out_o),
    .slot_o       (slot_o)
  );

endmodule
`default_nettype wire
